// ===== design/jdp_pkg.sv =====
// ----------------------------------------------------------------------------
// jdp_pkg: shared types and constants for the joystick packetizer
// Field widths, register indexes, sequencer states and the axis flag bundle.
// ----------------------------------------------------------------------------
package jdp_pkg;

  // Converter reading width on the ports, and the rail resolution default
  localparam int SAMPLE_W      = 12;
  localparam int ADC_BITS_DEF  = 12;

  // Output scale: magnitudes run 0..255, one sign bit on top
  localparam int SCALE_SHIFT   = 8;
  localparam int CMD_W         = SCALE_SHIFT + 1;
  localparam int MAG_W         = SCALE_SHIFT;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Dividend is excess * 255, excess never wider than a sample
  localparam int DVD_W         = SAMPLE_W + SCALE_SHIFT;

  // One quotient bit above the 8-bit range flags saturation
  localparam int QUO_W         = SCALE_SHIFT + 1;

  // Configuration registers
  localparam int CENTER_W      = 12;
  localparam int DZ_W          = 11;
  localparam int INTERVAL_W    = 16;
  localparam int TIME_W        = 32;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD = 3'd3;

  localparam logic [CENTER_W-1:0]   X_CENTER_RST  = 12'd2790;
  localparam logic [CENTER_W-1:0]   Y_CENTER_RST  = 12'd2330;
  localparam logic [DZ_W-1:0]       DEAD_ZONE_RST = 11'd300;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd50;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DECIDE
  } seq_state_t;

  // Per-axis classification from the offset stage
  typedef struct packed {
    logic zero;  // inside dead zone or no excess: magnitude 0
    logic sat;   // span not positive: magnitude full scale, no divide
    logic neg;   // offset on the negative side
  } axis_flags_t;

endpackage

// ===== design/joystick_deadzone_packetizer.sv =====
// ----------------------------------------------------------------------------
// joystick_deadzone_packetizer: dead-zone scaling and change-driven packets
// Scales two joystick axes to -255..255 and emits a packet on change or
// after the resend interval.
// ----------------------------------------------------------------------------
// The send decision for a sample transaction follows acceptance: per axis,
// the offset stage forms the centre offset in ST_PREP, then the shared
// restoring divider (one quotient bit per cycle) works out the magnitude in
// ST_DIV and hands the result back; ST_DECIDE then settles whether a packet
// goes out. The next sample is accepted only once the sequencer is back in
// ST_IDLE. An axis inside the dead zone, or one whose span is not positive,
// skips the divider. The single divider, used first for throttle and then
// for steering, limits how closely samples can follow each other. in_stall
// stays high from acceptance until the decision is made; a packet waiting
// in the output register does not block the next sample, but a new packet
// is held back until the previous one is taken.
// Configuration writes take effect at once and must only be made while
// the block is idle.
// ----------------------------------------------------------------------------
module joystick_deadzone_packetizer #(
  parameter int ADC_BITS = jdp_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [jdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jdp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [jdp_pkg::SAMPLE_W-1:0]      x_sample,
  input  logic [jdp_pkg::SAMPLE_W-1:0]      y_sample,
  input  logic                              button_level,
  input  logic [jdp_pkg::TIME_W-1:0]        now_ms,
  // packet channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [jdp_pkg::CMD_W-1:0]  throttle,
  output logic signed [jdp_pkg::CMD_W-1:0]  steering,
  output logic                              inverted_mode
);

  localparam int DIV_W = (ADC_BITS > jdp_pkg::SAMPLE_W) ? ADC_BITS : jdp_pkg::SAMPLE_W;

  // configuration registers
  logic [jdp_pkg::CENTER_W-1:0]   x_center;
  logic [jdp_pkg::CENTER_W-1:0]   y_center;
  logic [jdp_pkg::DZ_W-1:0]       dead_zone;
  logic [jdp_pkg::INTERVAL_W-1:0] send_interval_ms;

  // persistent state
  logic                              steer_inverted;
  logic                              prev_button;
  logic signed [jdp_pkg::CMD_W-1:0]  prev_throttle;
  logic signed [jdp_pkg::CMD_W-1:0]  prev_steering;
  logic                              sent_any;
  logic [jdp_pkg::TIME_W-1:0]        last_send_ms;

  // held sample and per-item working values
  logic [jdp_pkg::SAMPLE_W-1:0]      x_hold, y_hold;
  logic [jdp_pkg::TIME_W-1:0]        now_hold;
  logic                              axis_sel;
  logic signed [jdp_pkg::CMD_W-1:0]  thr_val, str_val;

  jdp_pkg::seq_state_t state, state_next;

  // offset stage and divider
  jdp_pkg::axis_flags_t              flags;
  logic [jdp_pkg::DVD_W-1:0]         dividend;
  logic [DIV_W-1:0]                  divisor;
  logic                              div_start, div_done;
  logic [jdp_pkg::MAG_W-1:0]         div_mag;

  // sequencer controls
  logic                              accept;
  logic                              axis_store;
  logic                              send, send_load;
  logic [jdp_pkg::MAG_W-1:0]         mag_sel;
  logic signed [jdp_pkg::CMD_W-1:0]  mag_pos, mag_neg;
  logic [jdp_pkg::TIME_W-1:0]        elapsed;

  // Configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      x_center         <= jdp_pkg::X_CENTER_RST;
      y_center         <= jdp_pkg::Y_CENTER_RST;
      dead_zone        <= jdp_pkg::DEAD_ZONE_RST;
      send_interval_ms <= jdp_pkg::INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jdp_pkg::REG_X_CENTER:    x_center         <= cfg_data[jdp_pkg::CENTER_W-1:0];
        jdp_pkg::REG_Y_CENTER:    y_center         <= cfg_data[jdp_pkg::CENTER_W-1:0];
        jdp_pkg::REG_DEAD_ZONE:   dead_zone        <= cfg_data[jdp_pkg::DZ_W-1:0];
        jdp_pkg::REG_SEND_PERIOD: send_interval_ms <= cfg_data[jdp_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset stage works on throttle first, then steering
  jdp_axis_prep #(
    .ADC_BITS (ADC_BITS)
  ) u_prep (
    .sample    (axis_sel ? y_hold : x_hold),
    .center    (axis_sel ? y_center : x_center),
    .dead_zone (dead_zone),
    .flags     (flags),
    .dividend  (dividend),
    .divisor   (divisor)
  );

  jdp_scale_div #(
    .ADC_BITS (ADC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .mag      (div_mag)
  );

  // Magnitude of the axis being finished: fixed value when no divide was made
  always_comb begin
    if (state == jdp_pkg::ST_PREP) begin
      mag_sel = flags.sat ? jdp_pkg::MAG_MAX : '0;
    end else begin
      mag_sel = div_mag;
    end
    mag_pos = $signed({1'b0, mag_sel});
    mag_neg = -mag_pos;
  end

  // Send when a value changed, on the first packet, or when the interval ran out
  always_comb begin
    elapsed = now_hold - last_send_ms;
    send    = !sent_any || (thr_val != prev_throttle) || (str_val != prev_steering) ||
              (elapsed > jdp_pkg::TIME_W'(send_interval_ms));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      jdp_pkg::ST_IDLE: begin
        if (in_valid) state_next = jdp_pkg::ST_PREP;
      end
      jdp_pkg::ST_PREP: begin
        if (flags.zero || flags.sat) begin
          state_next = axis_sel ? jdp_pkg::ST_DECIDE : jdp_pkg::ST_PREP;
        end else begin
          state_next = jdp_pkg::ST_DIV;
        end
      end
      jdp_pkg::ST_DIV: begin
        if (div_done) state_next = axis_sel ? jdp_pkg::ST_DECIDE : jdp_pkg::ST_PREP;
      end
      jdp_pkg::ST_DECIDE: begin
        if (!send || !out_valid || !out_stall) state_next = jdp_pkg::ST_IDLE;
      end
      default: state_next = jdp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall   = (state != jdp_pkg::ST_IDLE);
    accept     = in_valid && !in_stall;
    div_start  = (state == jdp_pkg::ST_PREP) && !flags.zero && !flags.sat;
    axis_store = ((state == jdp_pkg::ST_PREP) && (flags.zero || flags.sat)) ||
                 ((state == jdp_pkg::ST_DIV) && div_done);
    // hold a new packet until the output register is free or being drained
    send_load  = (state == jdp_pkg::ST_DECIDE) && send && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jdp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Button edge detection and axis sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      steer_inverted <= 1'b0;
      prev_button    <= 1'b1;
      axis_sel       <= 1'b0;
    end else begin
      if (accept) begin
        // falling edge of the active-low button toggles inversion
        if (prev_button && !button_level) steer_inverted <= !steer_inverted;
        prev_button <= button_level;
        axis_sel    <= 1'b0;
      end else if (axis_store && !axis_sel) begin
        axis_sel <= 1'b1;
      end
    end
  end

  // Hold the sample for the whole transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      x_hold   <= x_sample;
      y_hold   <= y_sample;
      now_hold <= now_ms;
    end
  end

  // Throttle is negated; steering is negated while inverted
  always_ff @(posedge clk) begin
    if (axis_store) begin
      if (!axis_sel) begin
        thr_val <= flags.neg ? mag_pos : mag_neg;
      end else begin
        str_val <= (flags.neg ^ steer_inverted) ? mag_neg : mag_pos;
      end
    end
  end

  // Last-sent values advance only when a packet goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_throttle <= '0;
      prev_steering <= '0;
      sent_any      <= 1'b0;
      last_send_ms  <= '0;
    end else if (send_load) begin
      prev_throttle <= thr_val;
      prev_steering <= str_val;
      sent_any      <= 1'b1;
      last_send_ms  <= now_hold;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send_load) begin
      throttle      <= thr_val;
      steering      <= str_val;
      inverted_mode <= steer_inverted;
    end
  end

  // The divider only finishes while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == jdp_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  // A pending packet implies the first send has been recorded
  a_valid_after_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sent_any)
    else $error("packet valid without a recorded send");

  // A new packet only appears out of the send decision
  a_packet_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == jdp_pkg::ST_DECIDE))
    else $error("packet raised outside the send decision");

endmodule

// ===== design/jdp_axis_prep.sv =====
// ----------------------------------------------------------------------------
// jdp_axis_prep: centre offset and dead-zone classification for one axis
// Forms the scaled dividend (excess * 255) and the span divisor.
// ----------------------------------------------------------------------------
module jdp_axis_prep #(
  parameter int ADC_BITS = jdp_pkg::ADC_BITS_DEF
) (
  input  logic [jdp_pkg::SAMPLE_W-1:0]  sample,
  input  logic [jdp_pkg::CENTER_W-1:0]  center,
  input  logic [jdp_pkg::DZ_W-1:0]      dead_zone,
  output jdp_pkg::axis_flags_t          flags,
  output logic [jdp_pkg::DVD_W-1:0]     dividend,
  output logic [((ADC_BITS > jdp_pkg::SAMPLE_W) ? ADC_BITS : jdp_pkg::SAMPLE_W)-1:0] divisor
);

  localparam int DIV_W  = (ADC_BITS > jdp_pkg::SAMPLE_W) ? ADC_BITS : jdp_pkg::SAMPLE_W;
  localparam int CALC_W = ((ADC_BITS > 13) ? ADC_BITS : 13) + 2;
  localparam logic signed [CALC_W-1:0] RAIL = CALC_W'((64'd1 << ADC_BITS) - 64'd1);

  logic signed [CALC_W-1:0] s_v, c_v, dz_v;
  logic signed [CALC_W-1:0] diff, mag, excess, span;
  logic                     pos, below;
  logic [jdp_pkg::SAMPLE_W-1:0] ex_n;

  always_comb begin
    s_v    = $signed(CALC_W'(sample));
    c_v    = $signed(CALC_W'(center));
    dz_v   = $signed(CALC_W'(dead_zone));
    diff   = s_v - c_v;
    mag    = diff[CALC_W-1] ? -diff : diff;
    below  = mag < dz_v;
    pos    = !diff[CALC_W-1] && (diff != '0);
    excess = pos ? (diff - dz_v) : (-diff - dz_v);
    span   = pos ? (RAIL - c_v - dz_v) : (c_v - dz_v);

    flags.zero = below || (excess == '0);
    flags.sat  = !flags.zero && (span[CALC_W-1] || (span == '0));
    flags.neg  = !pos;

    // excess never exceeds a sample magnitude once outside the dead zone
    ex_n     = excess[jdp_pkg::SAMPLE_W-1:0];
    dividend = {ex_n, jdp_pkg::SCALE_SHIFT'(0)} - jdp_pkg::DVD_W'(ex_n);
    divisor  = span[DIV_W-1:0];
  end

endmodule

// ===== design/jdp_scale_div.sv =====
// ----------------------------------------------------------------------------
// jdp_scale_div: shared restoring divider, one quotient bit per cycle
// Nine steps; a set top quotient bit saturates the magnitude at 255.
// ----------------------------------------------------------------------------
module jdp_scale_div #(
  parameter int ADC_BITS = jdp_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [jdp_pkg::DVD_W-1:0]     dividend,
  input  logic [((ADC_BITS > jdp_pkg::SAMPLE_W) ? ADC_BITS : jdp_pkg::SAMPLE_W)-1:0] divisor,
  output logic                          done,
  output logic [jdp_pkg::MAG_W-1:0]     mag
);

  localparam int DIV_W = (ADC_BITS > jdp_pkg::SAMPLE_W) ? ADC_BITS : jdp_pkg::SAMPLE_W;
  localparam int CMP_W = DIV_W + jdp_pkg::SCALE_SHIFT;
  localparam int CNT_W = $clog2(jdp_pkg::QUO_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [CMP_W-1:0]           rem, dsh;
  logic [jdp_pkg::QUO_W-1:0]  quo;
  logic                       fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(jdp_pkg::QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CMP_W'(dividend);
      dsh <= {divisor, jdp_pkg::SCALE_SHIFT'(0)};
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[jdp_pkg::QUO_W-2:0], fits};
    end
  end

  assign mag = quo[jdp_pkg::QUO_W-1] ? jdp_pkg::MAG_MAX : quo[jdp_pkg::MAG_W-1:0];

endmodule
